// ===== design/acfcd_pkg.sv =====
package acfcd_pkg;

	// Subframe length of the codec.
	localparam int ACFCD_SUBFRAME_LEN = 40;

	// Field widths.
	localparam int SIGN_W  = 4;
	localparam int POS_W   = 13;
	localparam int DELAY_W = 8;
	localparam int GAIN_W  = 14;
	localparam int SMP_W   = 16;

	// Pulse place width: 7*5+3+1 = 39 at most.
	localparam int PLACE_W = 6;

	// Unit pulse magnitude, +-1.0 in Q13.
	localparam logic signed [SMP_W-1:0] PULSE_POS = 16'sd8192;
	localparam logic signed [SMP_W-1:0] PULSE_NEG = -16'sd8192;

	// Rounding offset for the Q14 product.
	localparam logic signed [30:0] RND_Q14 = 31'sd8192;

	localparam logic signed [17:0] SAT_MAX = 18'sd32767;
	localparam logic signed [17:0] SAT_MIN = -18'sd32768;

endpackage

// ===== design/acelp_fixed_codebook_decode_top.sv =====
// Channel | Direction | Beat fields                                         | Handshake
// in      | input     | sign_bits, position_bits, pitch_delay, pitch_gain   | in_valid / in_stall
// out     | output    | sample, last                                        | out_valid / out_stall
//
// One in beat yields SUBFRAME_LEN out beats, one per cycle while out does not stall.
// The rate is set by the sample loop: one vector store write and at most one read per sample.
// The next in beat is taken in the cycle that computes the last sample of the current one.
// Reset clears the sequencer and the output valid; the vector store is not cleared.
// A stall on out freezes the sample loop, memory read register included; in stalls while busy.
module acelp_fixed_codebook_decode_top
	import acfcd_pkg::*;
#(
	parameter int SUBFRAME_LEN = ACFCD_SUBFRAME_LEN
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [SIGN_W-1:0]         sign_bits,
	input  logic [POS_W-1:0]          position_bits,
	input  logic [DELAY_W-1:0]        pitch_delay,
	input  logic [GAIN_W-1:0]         pitch_gain,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [SMP_W-1:0]   sample,
	output logic                      last
);

	localparam int CNT_W = $clog2(SUBFRAME_LEN);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SUBFRAME_LEN - 1);

	// Sequencer.
	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic             advance;
	logic             in_take;
	logic             final_smp;

	// Item held for the whole subframe.
	logic [SIGN_W-1:0]  sign_q;
	logic [PLACE_W-1:0] place_q [4];
	logic [DELAY_W-1:0] delay_q;
	logic [GAIN_W-1:0]  gain_q;

	// Vector store and its registered read port.
	logic signed [SMP_W-1:0] mem [SUBFRAME_LEN];
	logic signed [SMP_W-1:0] rdata_q;
	logic                    rd_en;
	logic [CNT_W-1:0]        rd_addr;
	logic [8:0]              ahead;

	// Output register; also forwards v[n-1] for a delay of one.
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] sample_q;
	logic                    last_q;

	// Datapath.
	logic signed [SMP_W-1:0] pulse;
	logic signed [SMP_W-1:0] prev;
	logic signed [30:0]      prod;
	logic signed [30:0]      rnd_sum;
	logic signed [16:0]      rnd;
	logic signed [17:0]      sum;
	logic signed [SMP_W-1:0] vnew;
	logic                    sharpen;

	assign advance   = busy_q && (!out_valid_q || !out_stall);
	assign final_smp = advance && (cnt_q == LAST_IDX);
	assign in_stall  = busy_q && !final_smp;
	assign in_take   = in_valid && !in_stall;

	// Pulse at the current sample; the four tracks never collide.
	always_comb begin
		pulse = '0;
		for (int k = 0; k < 4; k++) begin
			if ({{(8-PLACE_W){1'b0}}, place_q[k]} == {{(8-CNT_W){1'b0}}, cnt_q}) begin
				pulse = sign_q[k] ? PULSE_POS : PULSE_NEG;
			end
		end
	end

	// Delay zero sharpens by the raw pulse, delay one by the sample just made.
	always_comb begin
		if (delay_q == 8'd0) begin
			prev = pulse;
		end else if (delay_q == 8'd1) begin
			prev = sample_q;
		end else begin
			prev = rdata_q;
		end
	end

	assign sharpen = ({{(8-CNT_W){1'b0}}, cnt_q} >= delay_q);
	assign prod    = $signed(prev) * $signed({1'b0, gain_q});
	assign rnd_sum = prod + RND_Q14;
	assign rnd     = rnd_sum[30:14];

	always_comb begin
		sum = 18'(pulse);
		if (sharpen) begin
			sum = 18'(pulse) + 18'(rnd);
		end
		if (sum > SAT_MAX) begin
			vnew = SAT_MAX[SMP_W-1:0];
		end else if (sum < SAT_MIN) begin
			vnew = SAT_MIN[SMP_W-1:0];
		end else begin
			vnew = sum[SMP_W-1:0];
		end
	end

	// Read v[n+1-d] for the next sample; entries at n-1 and below are already written.
	assign ahead   = 9'(cnt_q) + 9'd1;
	assign rd_en   = advance && (cnt_q != LAST_IDX) && (delay_q >= 8'd2)
	                 && (ahead >= 9'(delay_q));
	assign rd_addr = CNT_W'(ahead - 9'(delay_q));

	always_ff @(posedge clk) begin
		if (advance) begin
			mem[cnt_q] <= vnew;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (final_smp) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else if (advance) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sign_q     <= sign_bits;
			delay_q    <= pitch_delay;
			gain_q     <= pitch_gain;
			place_q[0] <= PLACE_W'({3'b0, position_bits[2:0]} * 6'd5);
			place_q[1] <= PLACE_W'({3'b0, position_bits[5:3]} * 6'd5 + 6'd1);
			place_q[2] <= PLACE_W'({3'b0, position_bits[8:6]} * 6'd5 + 6'd2);
			place_q[3] <= PLACE_W'({3'b0, position_bits[12:10]} * 6'd5 + 6'd3
			                       + {5'b0, position_bits[9]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= vnew;
			last_q   <= (cnt_q == LAST_IDX);
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= LAST_IDX))
		else $error("sample counter out of range");

	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("output beat without an item in work");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		final_smp |=> (out_valid_q && last_q))
		else $error("last sample not flagged");

	a_take_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (busy_q && (cnt_q == '0)))
		else $error("item taken but loop not started");

	a_no_take_midway: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !final_smp) |-> !in_take)
		else $error("item taken during subframe");

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import acfcd_pkg::*;

	// Run limit in clock cycles. The slowest correct run is about 370 subframes of
	// 40 beats each under a 62 percent receiver stall, plus the hold-off stretch.
	// This limit leaves plenty of margin for that.
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS  = 30;

	typedef struct {
		logic signed [SMP_W-1:0] sample;
		logic                    last;
	} smp_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [SIGN_W-1:0]       sign_bits = '0;
	logic [POS_W-1:0]        position_bits = '0;
	logic [DELAY_W-1:0]      pitch_delay = '0;
	logic [GAIN_W-1:0]       pitch_gain = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [SMP_W-1:0] sample;
	logic                    last;

	// Expected codebook samples, oldest first.
	smp_beat_t expected_samples[$];

	int  err_cnt = 0;
	int  beat_cnt = 0;
	int  cycle_cnt = 0;
	int  snd_idle_pct = 0;
	int  rcv_idle_pct = 0;
	logic hold_req = 1'b0;
	int  hold_left = 0;

	acelp_fixed_codebook_decode_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sign_bits     (sign_bits),
		.position_bits (position_bits),
		.pitch_delay   (pitch_delay),
		.pitch_gain    (pitch_gain),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample        (sample),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still due", cycle_cnt,
				expected_samples.size());
			$display("[acelp_fixed_codebook_decode_top] ERROR");
			$finish;
		end
	end

	// Subframe predictor: place four signed unit pulses on the interleaved tracks,
	// then run the pitch sharpening recursion in place. Every right-hand value is
	// already sharpened, so a short delay compounds. A delay of zero sharpens a
	// sample by itself. A delay of 40 or more leaves the pulses alone.
	function automatic void predict_subframe(input logic [SIGN_W-1:0] sg,
		input logic [POS_W-1:0] ps, input logic [DELAY_W-1:0] dl,
		input logic [GAIN_W-1:0] gn);
		int        vec[ACFCD_SUBFRAME_LEN];
		int        place[4];
		int        prod;
		int        acc;
		int        n;
		smp_beat_t beat;
		for (n = 0; n < ACFCD_SUBFRAME_LEN; n++)
			vec[n] = 0;
		place[0] = int'(ps[2:0]) * 5;
		place[1] = int'(ps[5:3]) * 5 + 1;
		place[2] = int'(ps[8:6]) * 5 + 2;
		// Track 3 moves one sample further when the jump bit is set.
		place[3] = int'(ps[12:10]) * 5 + 3 + int'(ps[9]);
		for (n = 0; n < 4; n++)
			if (place[n] < ACFCD_SUBFRAME_LEN)
				vec[place[n]] = sg[n] ? 8192 : -8192;
		for (n = int'(dl); n < ACFCD_SUBFRAME_LEN; n++) begin
			prod = vec[n - int'(dl)] * int'(gn);
			// Q14 rounding, floor of (x + 0.5); >>> keeps the sign.
			acc  = vec[n] + ((prod + 8192) >>> 14);
			if (acc > 32767)
				acc = 32767;
			else if (acc < -32768)
				acc = -32768;
			vec[n] = acc;
		end
		for (n = 0; n < ACFCD_SUBFRAME_LEN; n++) begin
			beat.sample = vec[n][SMP_W-1:0];
			beat.last   = (n == ACFCD_SUBFRAME_LEN - 1);
			expected_samples.push_back(beat);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTS)
			$display("mismatch on beat %0d, %s: got %0d, want %0d", beat_cnt, what, got,
				want);
	endtask

	// One subframe beat on the in channel. Inputs change on the falling edge. The
	// payload stays put until the handshake at a rising edge. Gaps go in up front,
	// so the valid line never drops and rises in the same step.
	task automatic send_subframe(input logic [SIGN_W-1:0] sg, input logic [POS_W-1:0] ps,
		input logic [DELAY_W-1:0] dl, input logic [GAIN_W-1:0] gn);
		while ($urandom_range(99) < snd_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		sign_bits     <= sg;
		position_bits <= ps;
		pitch_delay   <= dl;
		pitch_gain    <= gn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_subframe(sg, ps, dl, gn);
	endtask

	// Random subframe. Most delays sit in the codec's legal range, and about half
	// of those are below 40, where the sharpening is active. The rest span the whole
	// 8-bit field, zero and very short delays included. The gain is often at an end.
	task automatic send_random_subframe();
		logic [DELAY_W-1:0] dl;
		logic [GAIN_W-1:0]  gn;
		case ($urandom_range(9))
			0: begin
				dl = DELAY_W'($urandom_range(255));
			end
			1: begin
				dl = DELAY_W'($urandom_range(18));
			end
			2, 3, 4, 5: begin
				dl = DELAY_W'($urandom_range(39, 19));
			end
			default: begin
				dl = DELAY_W'($urandom_range(143, 40));
			end
		endcase
		case ($urandom_range(7))
			0: begin
				gn = '0;
			end
			1: begin
				gn = '1;
			end
			default: begin
				gn = GAIN_W'($urandom());
			end
		endcase
		send_subframe(SIGN_W'($urandom()), POS_W'($urandom()), dl, gn);
	endtask

	// Drop valid before waiting, so the last beat is not taken a second time.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random stall at the set rate. A hold-off request pins the stall high
	// for a counted stretch, so the block fills up and stalls the in channel.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Checker: every accepted out beat is matched against the oldest expectation.
	always @(posedge clk) begin : check_beats
		smp_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				report_mismatch("beat with nothing expected", int'(sample), 0);
			end else begin
				want = expected_samples.pop_front();
				if (sample !== want.sample)
					report_mismatch("sample", int'(sample), int'(want.sample));
				if (last !== want.last)
					report_mismatch("last", int'(last), int'(want.last));
			end
			beat_cnt++;
		end
	end

	// Directed subframes: field extremes, the jump bit, delays of zero, below 19,
	// at the edges of the active range and far beyond it. It also runs the longest
	// same-sign build-up at delay one and full gain, which comes closest to the clamp.
	task automatic test_directed();
		send_subframe(4'h0, 13'h0000, 8'd40, 14'd0);
		send_subframe(4'hF, 13'h1FFF, 8'd143, 14'h3FFF);
		send_subframe(4'hF, 13'h0000, 8'd1, 14'h3FFF);
		send_subframe(4'h0, 13'h0000, 8'd1, 14'h3FFF);
		send_subframe(4'h5, 13'h1555, 8'd0, 14'h3FFF);
		send_subframe(4'hA, 13'h0AAA, 8'd0, 14'd0);
		send_subframe(4'hA, 13'h0AAA, 8'd19, 14'd8192);
		send_subframe(4'hF, 13'h0000, 8'd39, 14'h3FFF);
		send_subframe(4'h3, 13'h1FFF, 8'd255, 14'h3FFF);
		send_subframe(4'h8, 13'h0200, 8'd4, 14'd10000);
		send_subframe(4'h8, 13'h1E00, 8'd20, 14'h3FFF);
		send_subframe(4'h7, 13'h01FF, 8'd2, 14'h3FFF);
		send_subframe(4'h3, 13'h1234, 8'd5, 14'd12345);
		send_subframe(4'hC, 13'h0F0F, 8'd18, 14'd1);
		send_subframe(4'h9, 13'h0000, 8'd2, 14'h3FFF);
		send_subframe(4'hF, 13'h1FFF, 8'd40, 14'h3FFF);
		send_subframe(4'h6, 13'h13C9, 8'd128, 14'h2000);
		send_subframe(4'h1, 13'h0E38, 8'd3, 14'h1FFF);
	endtask

	task automatic test_random_subframes(input int count, input int snd_pct,
		input int rcv_pct);
		int k;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		for (k = 0; k < count; k++)
			send_random_subframe();
	endtask

	// Long receiver hold-off while the sender keeps offering beats back to back.
	task automatic test_output_holdoff();
		int k;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		hold_req     = 1'b1;
		for (k = 0; k < 6; k++)
			send_random_subframe();
		wait_drained();
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		snd_idle_pct = 9;
		rcv_idle_pct = 62;
		test_directed();
		test_random_subframes(130, 9, 62);
		test_random_subframes(120, 62, 9);
		test_output_holdoff();
		test_random_subframes(100, 0, 0);

		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		// Let stray beats show up after the last expected one.
		repeat (3 * ACFCD_SUBFRAME_LEN)
			@(posedge clk);

		if (err_cnt == 0) begin
			$display("[acelp_fixed_codebook_decode_top] OK");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("[acelp_fixed_codebook_decode_top] ERROR");
		end
		$finish;
	end

endmodule
